### src/reaction_diffusion_euler_step_core_macros.svh
// Assertion macros shared by the reaction-diffusion step core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef REACTION_DIFFUSION_EULER_STEP_CORE_MACROS_SVH
`define REACTION_DIFFUSION_EULER_STEP_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RDES_ASSERT(NAME, PROP, MSG) \
  NAME: assert property (@(posedge clk) disable iff (rst) PROP) else $error(MSG);

// Condition in one cycle that implies a consequence in the next cycle.
`define RDES_ASSERT_NEXT(NAME, ANTE, CONS, MSG) \
  NAME: assert property (@(posedge clk) disable iff (rst) (ANTE) |=> (CONS)) else $error(MSG);

`endif

### src/rdes_pkg.sv
// Shared types and constants for the reaction-diffusion step core.
// Used by the configuration, controller, datapath and top-level modules.
package rdes_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int MIN_SIZE     = 3;

  localparam int DATA_W      = 32;
  localparam int GAIN_W      = 25;
  localparam int SIZE_W      = 7;
  localparam int IDX_W       = 12;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_U    = 3'd0,
    CFG_DIFF_V    = 3'd1,
    CFG_FEED      = 3'd2,
    CFG_KILL      = 3'd3,
    CFG_ROW_COUNT = 3'd4,
    CFG_COL_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CENTER,
    RD_NBR,
    RD_RESULT
  } rd_kind_t;

  typedef enum logic [2:0] {
    M_UV,
    M_UV2,
    M_DU,
    M_DV,
    M_FU,
    M_FKV
  } mul_sel_t;

  typedef enum logic [2:0] {
    NB_CENTER,
    NB_UP,
    NB_DOWN,
    NB_LEFT,
    NB_RIGHT
  } nbr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] du;
    logic [GAIN_W-1:0] dv;
    logic [GAIN_W-1:0] f;
    logic [GAIN_W:0]   fk;
  } gains_t;

  typedef struct packed {
    logic     mem_we_in;
    rd_kind_t rd_kind;
    logic     res_clear;
    logic     clr_sat;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     wr_step;
    logic     out_load;
    logic     out_step;
    logic     out_range;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

### src/rdes_cfg.sv
// Configuration registers of the reaction-diffusion step core.
// Clamps the grid size and derives the cell count; depends on rdes_pkg.
module rdes_cfg #(
  parameter int MAX_ROWS = rdes_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rdes_pkg::MAX_COLS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [rdes_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [rdes_pkg::GAIN_W-1:0]                  cfg_data,
  output rdes_pkg::gains_t                             gains,
  output logic [$clog2(MAX_ROWS+1)-1:0]                rows,
  output logic [$clog2(MAX_COLS+1)-1:0]                cols,
  output logic [$clog2(MAX_ROWS*MAX_COLS):0]           total
);
  import rdes_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int TOT_W = $clog2(MAX_ROWS * MAX_COLS) + 1;

  logic [GAIN_W-1:0] diffusion_u;
  logic [GAIN_W-1:0] diffusion_v;
  logic [GAIN_W-1:0] feed_rate;
  logic [GAIN_W-1:0] kill_rate;
  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_u <= '0;
      diffusion_v <= '0;
      feed_rate   <= '0;
      kill_rate   <= '0;
      row_count   <= SIZE_W'(64);
      col_count   <= SIZE_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIFF_U:    diffusion_u <= cfg_data;
        CFG_DIFF_V:    diffusion_v <= cfg_data;
        CFG_FEED:      feed_rate   <= cfg_data;
        CFG_KILL:      kill_rate   <= cfg_data;
        CFG_ROW_COUNT: row_count   <= cfg_data[SIZE_W-1:0];
        CFG_COL_COUNT: col_count   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes outside the supported range are clamped to it.
  always_comb begin
    if (row_count < SIZE_W'(MIN_SIZE)) begin
      rows = ROW_W'(MIN_SIZE);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = ROW_W'(row_count);
    end
    if (col_count < SIZE_W'(MIN_SIZE)) begin
      cols = COL_W'(MIN_SIZE);
    end else if (32'(col_count) > MAX_COLS) begin
      cols = COL_W'(MAX_COLS);
    end else begin
      cols = COL_W'(col_count);
    end
  end

  assign total    = TOT_W'(TOT_W'(rows) * TOT_W'(cols));
  assign gains.du = diffusion_u;
  assign gains.dv = diffusion_v;
  assign gains.f  = feed_rate;
  assign gains.fk = (GAIN_W+1)'(feed_rate) + (GAIN_W+1)'(kill_rate);

endmodule

### src/rdes_ctrl.sv
// Controller of the reaction-diffusion step core: input handshake, grid walk,
// neighbor addressing and the per-cell sequence. Depends on rdes_pkg and macros.
`include "reaction_diffusion_euler_step_core_macros.svh"

module rdes_ctrl #(
  parameter int MAX_ROWS = rdes_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rdes_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  rdes_pkg::op_t                          op,
  input  logic [rdes_pkg::IDX_W-1:0]             cell_index,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          rows,
  input  logic [$clog2(MAX_COLS+1)-1:0]          cols,
  input  logic [$clog2(MAX_ROWS*MAX_COLS):0]     total,
  input  rdes_pkg::dp_stat_t                     stat,
  output rdes_pkg::cmd_t                         cmd,
  output logic [$clog2(MAX_ROWS*MAX_COLS):0]     rd_addr,
  output logic [$clog2(MAX_ROWS*MAX_COLS):0]     wr_addr
);
  import rdes_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int CELL_W = $clog2(MAX_ROWS * MAX_COLS);
  localparam int TOT_W  = CELL_W + 1;
  localparam int ADDR_W = CELL_W + 1;
  localparam int CMP_W  = (TOT_W > IDX_W) ? TOT_W : IDX_W;

  state_t            state;
  state_t            state_next;
  logic              active_bank;
  op_t               op_q;
  logic              range_q;
  nbr_t              slot;
  mul_sel_t          mslot;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  c;
  logic [CELL_W-1:0] k;

  logic              in_range;
  logic [CELL_W-1:0] idx_cell;
  logic [CELL_W-1:0] cols_c;
  logic [CELL_W-1:0] last_base;
  logic              r_last;
  logic              c_last;
  logic [CELL_W-1:0] nbr_cell;

  assign in_range  = CMP_W'(cell_index) < CMP_W'(total);
  assign idx_cell  = CELL_W'(CMP_W'(cell_index));
  assign cols_c    = CELL_W'(cols);
  assign last_base = CELL_W'(total - TOT_W'(cols));
  assign r_last    = (r == ROW_W'(rows - 1'b1));
  assign c_last    = (c == COL_W'(cols - 1'b1));

  // Neighbor of cell k on the torus; each result lies below the cell count.
  always_comb begin
    unique case (slot)
      NB_CENTER: nbr_cell = k;
      NB_UP:     nbr_cell = (r == '0) ? k + last_base : k - cols_c;
      NB_DOWN:   nbr_cell = r_last ? k - last_base : k + cols_c;
      NB_LEFT:   nbr_cell = (c == '0) ? k + cols_c - 1'b1 : k - 1'b1;
      NB_RIGHT:  nbr_cell = c_last ? k - cols_c + 1'b1 : k + 1'b1;
      default:   nbr_cell = k;
    endcase
  end

  assign rd_addr = (state == ST_IDLE) ? {active_bank, idx_cell} : {active_bank, nbr_cell};
  assign wr_addr = (state == ST_IDLE) ? {active_bank, idx_cell} : {~active_bank, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
      op_q        <= OP_NONE;
      range_q     <= 1'b0;
      slot        <= NB_CENTER;
      mslot       <= M_UV;
      r           <= '0;
      c           <= '0;
      k           <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_q    <= op;
            range_q <= ((op == OP_WRITE) || (op == OP_READ)) && !in_range;
            slot    <= NB_CENTER;
            r       <= '0;
            c       <= '0;
            k       <= '0;
          end
        end
        ST_READ: begin
          unique case (slot)
            NB_CENTER: slot <= NB_UP;
            NB_UP:     slot <= NB_DOWN;
            NB_DOWN:   slot <= NB_LEFT;
            NB_LEFT:   slot <= NB_RIGHT;
            default:   mslot <= M_UV;
          endcase
        end
        ST_ACC: begin
          unique case (mslot)
            M_UV:    mslot <= M_UV2;
            M_UV2:   mslot <= M_DU;
            M_DU:    mslot <= M_DV;
            M_DV:    mslot <= M_FU;
            M_FU:    mslot <= M_FKV;
            default: mslot <= M_UV;
          endcase
        end
        ST_WRITE: begin
          slot <= NB_CENTER;
          k    <= k + 1'b1;
          if (c_last) begin
            c <= '0;
            if (r_last) begin
              active_bank <= ~active_bank;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (op)
            OP_WRITE: begin
              cmd.mem_we_in = in_range;
              cmd.res_clear = 1'b1;
              state_next    = ST_DONE;
            end
            OP_READ: begin
              if (in_range) begin
                cmd.rd_kind = RD_RESULT;
                state_next  = ST_RD_WAIT;
              end else begin
                cmd.res_clear = 1'b1;
                state_next    = ST_DONE;
              end
            end
            OP_STEP: begin
              cmd.res_clear = 1'b1;
              cmd.clr_sat   = 1'b1;
              state_next    = ST_READ;
            end
            default: begin
              cmd.res_clear = 1'b1;
              state_next    = ST_DONE;
            end
          endcase
        end
      end
      ST_RD_WAIT: state_next = ST_DONE;
      ST_READ: begin
        cmd.rd_kind = (slot == NB_CENTER) ? RD_CENTER : RD_NBR;
        if (slot == NB_RIGHT) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mslot;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = (mslot == M_FKV) ? ST_WRITE : ST_MUL;
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        state_next  = (c_last && r_last) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_step  = (op_q == OP_STEP);
          cmd.out_range = range_q;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RDES_ASSERT(a_in_write_idle, (state != ST_IDLE) |-> !cmd.mem_we_in, "input write outside idle")
  `RDES_ASSERT(a_bank_flip, (active_bank != $past(active_bank)) |-> ($past(state) == ST_WRITE), "bank changed outside a step write")
  `RDES_ASSERT(a_walk_range, (state == ST_READ) |-> ((r < rows) && (32'(c) < 32'(cols))), "grid walk out of range")
  `RDES_ASSERT(a_step_bank, cmd.wr_step |-> (wr_addr[ADDR_W-1] != active_bank), "step wrote the active bank")
  `RDES_ASSERT_NEXT(a_step_start, (state == ST_IDLE) && s_tvalid && (op == OP_STEP), (state == ST_READ) && (slot == NB_CENTER) && (k == '0), "step did not start at the first cell")

endmodule

### src/rdes_dp.sv
// Datapath of the reaction-diffusion step core: two-bank u/v store, shared
// multiplier with rounding, saturation and the output register. Depends on rdes_pkg.
module rdes_dp #(
  parameter int MAX_ROWS = rdes_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rdes_pkg::MAX_COLS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  rdes_pkg::cmd_t                           cmd,
  output rdes_pkg::dp_stat_t                       stat,
  input  logic [$clog2(MAX_ROWS*MAX_COLS):0]       rd_addr,
  input  logic [$clog2(MAX_ROWS*MAX_COLS):0]       wr_addr,
  input  logic signed [rdes_pkg::DATA_W-1:0]       in_u,
  input  logic signed [rdes_pkg::DATA_W-1:0]       in_v,
  input  rdes_pkg::gains_t                         gains,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [rdes_pkg::OUT_TDATA_W-1:0]         m_tdata
);
  import rdes_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS) + 1;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int LAP_W   = 36;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = LAP_W + MUL_B_W;
  localparam int RND_W   = PROD_W - 24;
  localparam int ACC_W   = 48;
  localparam int PAD_W   = OUT_TDATA_W - 2 * DATA_W - STAT_W;

  localparam logic signed [LAP_W-1:0]  Q_ONE  = LAP_W'(64'sd16777216);
  localparam logic signed [PROD_W-1:0] Q_HALF = PROD_W'(64'sd8388608);
  localparam logic signed [ACC_W-1:0]  LIM_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  LIM_LO = ACC_W'(-64'sd2147483648);

  function automatic logic ovf32(input logic signed [ACC_W-1:0] x);
    return (x > LIM_HI) || (x < LIM_LO);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > LIM_HI) begin
      return LIM_HI[DATA_W-1:0];
    end else if (x < LIM_LO) begin
      return LIM_LO[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  logic signed [DATA_W-1:0] u_mem [DEPTH];
  logic signed [DATA_W-1:0] v_mem [DEPTH];
  logic signed [DATA_W-1:0] rdu;
  logic signed [DATA_W-1:0] rdv;
  rd_kind_t                 rd_kind_q;

  logic signed [DATA_W-1:0]  cu;
  logic signed [DATA_W-1:0]  cv;
  logic signed [LAP_W-1:0]   lap_u;
  logic signed [LAP_W-1:0]   lap_v;
  logic signed [LAP_W-1:0]   omu;
  logic signed [DATA_W-1:0]  uv;
  logic signed [ACC_W-1:0]   nu;
  logic signed [ACC_W-1:0]   nv;
  logic signed [PROD_W-1:0]  prod;
  mul_sel_t                  sel_q;
  logic                      sat_flag;
  logic signed [DATA_W-1:0]  res_u;
  logic signed [DATA_W-1:0]  res_v;

  logic signed [LAP_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  biased;
  logic signed [ACC_W-1:0]   rnd;
  logic                      mem_we;
  logic signed [DATA_W-1:0]  wd_u;
  logic signed [DATA_W-1:0]  wd_v;

  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_u;
  logic signed [DATA_W-1:0]  out_v;
  status_t                   out_status;

  assign mem_we = cmd.mem_we_in | cmd.wr_step;
  assign wd_u   = cmd.wr_step ? sat32(nu) : in_u;
  assign wd_v   = cmd.wr_step ? sat32(nv) : in_v;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      u_mem[wr_addr] <= wd_u;
      v_mem[wr_addr] <= wd_v;
    end
    rdu <= u_mem[rd_addr];
    rdv <= v_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_kind_q <= RD_NONE;
    end else begin
      rd_kind_q <= cmd.rd_kind;
    end
  end

  // The center read seeds the Laplacian with -4x, so the four neighbor reads
  // leave the finished Laplacian behind.
  always_ff @(posedge clk) begin
    case (rd_kind_q)
      RD_CENTER: begin
        cu    <= rdu;
        cv    <= rdv;
        nu    <= ACC_W'(rdu);
        nv    <= ACC_W'(rdv);
        lap_u <= -(LAP_W'(rdu) <<< 2);
        lap_v <= -(LAP_W'(rdv) <<< 2);
        omu   <= Q_ONE - LAP_W'(rdu);
      end
      RD_NBR: begin
        lap_u <= lap_u + LAP_W'(rdu);
        lap_v <= lap_v + LAP_W'(rdv);
      end
      RD_RESULT: begin
        res_u <= rdu;
        res_v <= rdv;
      end
      default: ;
    endcase
    if (cmd.res_clear) begin
      res_u <= '0;
      res_v <= '0;
    end
    if (cmd.acc_en) begin
      case (sel_q)
        M_UV:   uv <= sat32(rnd);
        M_UV2: begin
          nu <= nu - rnd;
          nv <= nv + rnd;
        end
        M_DU:   nu <= nu + rnd;
        M_DV:   nv <= nv + rnd;
        M_FU:   nu <= nu + rnd;
        M_FKV:  nv <= nv - rnd;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      M_UV: begin
        mul_a = LAP_W'(cu);
        mul_b = cv;
      end
      M_UV2: begin
        mul_a = LAP_W'(uv);
        mul_b = cv;
      end
      M_DU: begin
        mul_a = lap_u;
        mul_b = $signed(MUL_B_W'(gains.du));
      end
      M_DV: begin
        mul_a = lap_v;
        mul_b = $signed(MUL_B_W'(gains.dv));
      end
      M_FU: begin
        mul_a = omu;
        mul_b = $signed(MUL_B_W'(gains.f));
      end
      M_FKV: begin
        mul_a = LAP_W'(cv);
        mul_b = $signed(MUL_B_W'(gains.fk));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod  <= PROD_W'(mul_a) * PROD_W'(mul_b);
      sel_q <= cmd.mul_sel;
    end
  end

  // Round half up back to 24 fractional bits; the shift is arithmetic (floor).
  assign biased = prod + Q_HALF;
  assign rnd    = ACC_W'(RND_W'(biased >>> 24));

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
    end else if (cmd.clr_sat) begin
      sat_flag <= 1'b0;
    end else if (cmd.acc_en && (sel_q == M_UV) && ovf32(rnd)) begin
      sat_flag <= 1'b1;
    end else if (cmd.wr_step && (ovf32(nu) || ovf32(nv))) begin
      sat_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_u <= res_u;
      out_v <= res_v;
      if (cmd.out_range) begin
        out_status <= STATUS_RANGE;
      end else if (cmd.out_step && sat_flag) begin
        out_status <= STATUS_SAT;
      end else begin
        out_status <= STATUS_OK;
      end
    end
  end

  assign stat.out_busy = out_valid && !m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = {{PAD_W{1'b0}}, out_status, out_v, out_u};

endmodule

### src/reaction_diffusion_euler_step_core.sv
// Reaction-diffusion explicit Euler step core. Holds u and v grids on a torus
// in a two-bank store and takes one command per input transfer: write a cell,
// read a cell, or advance the whole grid by one explicit Euler step. Every
// command gives exactly one result transfer. A write, a command with an
// out-of-range index or the unused operation code goes from the idle state
// straight to the done state, which loads the result register once the output
// register is free; a read first passes through a read-wait state. A step
// walks the grid one cell at a time; for each cell it does five reads through
// the single read port of the store (center and four neighbors), six
// multiplications through the one shared multiplier, each followed by a
// rounding and accumulate cycle, and one write into the inactive bank. The
// input is taken only while the block is idle; a result waits in an output
// register so the next command can be accepted before the previous result is
// taken. Cells must be written before they are read or used by a step, since
// the store has no reset. Configuration registers are written through the
// plain write port; the user must write them only while the block is idle,
// which the block itself does not enforce.
module reaction_diffusion_euler_step_core #(
  parameter int MAX_ROWS = rdes_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rdes_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: operation[1:0], cell_index[13:2], u_value[45:14],
  // v_value[77:46], zero fill[79:78].
  input  logic [rdes_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0 up: u_result[31:0], v_result[63:32], status[65:64],
  // zero fill[71:66].
  output logic [rdes_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [rdes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rdes_pkg::GAIN_W-1:0]         cfg_data
);
  import rdes_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int CELL_W = $clog2(MAX_ROWS * MAX_COLS);

  // Unpacked input fields.
  op_t                      op;
  logic [IDX_W-1:0]         cell_index;
  logic signed [DATA_W-1:0] u_value;
  logic signed [DATA_W-1:0] v_value;

  assign op         = op_t'(s_tdata[OP_W-1:0]);
  assign cell_index = s_tdata[OP_W+IDX_W-1:OP_W];
  assign u_value    = $signed(s_tdata[OP_W+IDX_W+DATA_W-1:OP_W+IDX_W]);
  assign v_value    = $signed(s_tdata[OP_W+IDX_W+2*DATA_W-1:OP_W+IDX_W+DATA_W]);

  // Clamped grid size and gains from the configuration registers.
  gains_t            gains;
  logic [ROW_W-1:0]  rows;
  logic [COL_W-1:0]  cols;
  logic [CELL_W:0]   total;

  // Controller to datapath: commands, store addresses and status.
  cmd_t              cmd;
  dp_stat_t          stat;
  logic [CELL_W:0]   rd_addr;
  logic [CELL_W:0]   wr_addr;

  rdes_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains),
    .rows      (rows),
    .cols      (cols),
    .total     (total)
  );

  // The controller sequences each command; during a step it walks the cells
  // in row-major order and addresses the four torus neighbors of each one.
  rdes_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .op         (op),
    .cell_index (cell_index),
    .rows       (rows),
    .cols       (cols),
    .total      (total),
    .stat       (stat),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  // The datapath holds the store, the shared multiplier with round-half-up
  // and saturation, the step saturation flag and the result register.
  rdes_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .in_u     (u_value),
    .in_v     (v_value),
    .gains    (gains),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
